// ===== src/tspes_pkg.sv =====
`default_nettype none

package tspes_pkg;

    localparam int unsigned PACKET_BYTES = 188;
    localparam int unsigned POS_W        = 8;
    localparam int unsigned BEGIN_W      = 9;
    localparam int unsigned LEN_W        = 17;
    localparam int unsigned PID_W        = 13;

    localparam logic [7:0]       SYNC_BYTE     = 8'h47;
    localparam logic [PID_W-1:0] PID_RESET     = 13'h1FFF;
    localparam logic [POS_W-1:0] POS_SYNC      = 8'd0;
    localparam logic [POS_W-1:0] POS_PID_HI    = 8'd1;
    localparam logic [POS_W-1:0] POS_PID_LO    = 8'd2;
    localparam logic [POS_W-1:0] POS_CTL       = 8'd3;
    localparam logic [POS_W-1:0] POS_ADAPT_LEN = 8'd4;
    localparam logic [POS_W-1:0] POS_LAST      = POS_W'(PACKET_BYTES - 1);
    localparam logic [POS_W-1:0] POS_IDLE      = POS_W'(PACKET_BYTES);

    // PES header: length field sits at payload bytes 4 and 5
    localparam logic [7:0]       LEN_HI_INDEX  = 8'd4;
    localparam logic [7:0]       LEN_LO_INDEX  = 8'd5;
    localparam logic [LEN_W-1:0] PES_HDR_BYTES = 17'd6;

    typedef enum logic [2:0] {
        ST_IGNORED   = 3'd0,
        ST_BAD_SYNC  = 3'd1,
        ST_APPENDED  = 3'd2,
        ST_COMPLETE  = 3'd3,
        ST_OVERFLOW  = 3'd4,
        ST_MALFORMED = 3'd5
    } t_status;

    // Payload start past the packet, or a start packet too short for the length bytes
    function automatic logic is_malformed(input logic [BEGIN_W-1:0] payload_begin,
                                          input logic                unit_start);
        logic over;
        logic short_start;
        over        = payload_begin > BEGIN_W'(PACKET_BYTES);
        short_start = unit_start && (payload_begin > BEGIN_W'(PACKET_BYTES - 6));
        return over || short_start;
    endfunction

endpackage

`default_nettype wire

// ===== src/ts_pid_filter_pes_assembler.sv =====
// Transport stream PID filter and PES reassembler.
// Input channel (s_*): one stream byte per item in s_tdata[7:0]; s_tuser is set
// on the first byte of each 188-byte packet. A marker mid-packet drops the
// unfinished packet; bytes after a packet end with no new marker give an
// all-zero result.
// Output channel (m_*): exactly one result item per input item. m_tuser flags a
// PES payload byte of the selected PID with its PES offset; m_tlast marks the
// last byte of a packet, which carries the packet status, the completion flag
// and the committed PES length.
// Configuration: i_cfg_wr_en/i_cfg_wr_data load the PID; write it only while
// the block holds no undelivered item.
// Results are registered: valid in the cycle after accept. Throughput is one
// item per cycle: all parsing is counters and compares ahead of a single
// output register, and s_tready stays high while that register is empty or
// being drained in the same cycle.
// When m_tready is low the result is held and input stalls behind it.
// Reset (i_rst_n low, synchronous) clears all parse state, drops any pending
// result and sets the PID to 8191.
`default_nettype none

module ts_pid_filter_pes_assembler
    import tspes_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [PID_W-1:0]  i_cfg_wr_data,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,   // [7:0] ts_byte
    input  wire logic              s_tuser,   // [0] packet_start
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [47:0]            m_tdata,   // [7:0] payload_byte, [24:8] pes_offset,
                                              // [27:25] packet_status, [28] pes_complete,
                                              // [45:29] pes_length, [47:46] zero
    output logic                   m_tuser,   // [0] payload_valid
    output logic                   m_tlast    // packet_done
);

    logic [PID_W-1:0]   r_caption_pid;
    logic [POS_W-1:0]   r_byte_pos,   n_byte_pos;
    logic               r_sync_good,  n_sync_good;
    logic [4:0]         r_pid_hi,     n_pid_hi;
    logic               r_pid_match,  n_pid_match;
    logic               r_unit_start, n_unit_start;
    logic [1:0]         r_field_ctl,  n_field_ctl;
    logic [BEGIN_W-1:0] r_pay_begin,  n_pay_begin;
    logic               r_collecting, n_collecting;
    logic [LEN_W-1:0]   r_committed,  n_committed;
    logic [LEN_W-1:0]   r_target,     n_target;
    logic [7:0]         r_staged,     n_staged;
    logic [7:0]         r_len_hi,     n_len_hi;

    logic               r_out_valid;
    logic [47:0]        r_tdata;
    logic               r_tuser;
    logic               r_tlast;

    logic [47:0]        n_tdata;
    logic               n_tuser;
    logic               n_tlast;

    logic               accept;
    logic [POS_W-1:0]   pos;
    logic [7:0]         b;
    logic               stage;
    logic [LEN_W-1:0]   base;
    logic [LEN_W-1:0]   offset;
    logic [LEN_W:0]     total;
    t_status            status;
    logic               complete;

    assign s_tready = !r_out_valid || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_tdata;
    assign m_tuser  = r_tuser;
    assign m_tlast  = r_tlast;

    assign b   = s_tdata;
    assign pos = s_tuser ? POS_SYNC : r_byte_pos;

    always_comb begin
        n_byte_pos   = r_byte_pos;
        n_sync_good  = r_sync_good;
        n_pid_hi     = r_pid_hi;
        n_pid_match  = r_pid_match;
        n_unit_start = r_unit_start;
        n_field_ctl  = r_field_ctl;
        n_pay_begin  = r_pay_begin;
        n_collecting = r_collecting;
        n_committed  = r_committed;
        n_target     = r_target;
        n_staged     = r_staged;
        n_len_hi     = r_len_hi;
        stage        = 1'b0;
        base         = '0;
        offset       = '0;
        total        = '0;
        status       = ST_IGNORED;
        complete     = 1'b0;
        n_tdata      = '0;
        n_tuser      = 1'b0;
        n_tlast      = 1'b0;

        if (pos >= POS_IDLE) begin
            n_byte_pos = POS_IDLE;
        end else begin
            case (pos)
                POS_SYNC: begin
                    n_sync_good  = (b == SYNC_BYTE);
                    n_pid_match  = 1'b0;
                    n_unit_start = 1'b0;
                    n_field_ctl  = 2'd0;
                    n_pay_begin  = BEGIN_W'(4);
                    n_staged     = 8'd0;
                end
                POS_PID_HI: begin
                    n_pid_hi     = b[4:0];
                    n_unit_start = b[6];
                end
                POS_PID_LO: begin
                    n_pid_match = r_sync_good && ({r_pid_hi, b} == r_caption_pid);
                end
                POS_CTL: begin
                    n_field_ctl = b[5:4];
                    n_pay_begin = BEGIN_W'(4);
                end
                POS_ADAPT_LEN: begin
                    if (r_field_ctl[1]) begin
                        n_pay_begin = BEGIN_W'(5) + BEGIN_W'(b);
                    end
                end
                default: begin
                end
            endcase

            // stage a payload byte
            stage = (pos >= POS_ADAPT_LEN) && (BEGIN_W'(pos) >= n_pay_begin)
                    && n_pid_match && (n_unit_start || r_collecting)
                    && !is_malformed(n_pay_begin, n_unit_start);
            base  = n_unit_start ? '0 : r_committed;
            if (stage) begin
                offset  = base + LEN_W'(r_staged);
                n_tuser = 1'b1;
                if (n_unit_start) begin
                    if (r_staged == LEN_HI_INDEX) begin
                        n_len_hi = b;
                    end else if (r_staged == LEN_LO_INDEX) begin
                        n_target = {1'b0, r_len_hi, b} + PES_HDR_BYTES;
                    end
                end
                n_staged = r_staged + 8'd1;
            end

            // commit or reject at packet end
            if (pos == POS_LAST) begin
                n_tlast = 1'b1;
                total   = {1'b0, base} + (LEN_W + 1)'(n_staged);
                if (!n_sync_good) begin
                    status = ST_BAD_SYNC;
                end else if (!n_pid_match) begin
                    status = ST_IGNORED;
                end else if (is_malformed(n_pay_begin, n_unit_start)) begin
                    status = ST_MALFORMED;
                    if (n_unit_start) begin
                        n_collecting = 1'b0;
                        n_committed  = '0;
                        n_target     = '0;
                    end
                end else if (!n_unit_start && !r_collecting) begin
                    status = ST_IGNORED;
                end else begin
                    if (n_unit_start) begin
                        n_collecting = 1'b1;
                        n_committed  = '0;
                    end
                    if (total > {1'b0, n_target}) begin
                        status = ST_OVERFLOW;
                    end else begin
                        n_committed = total[LEN_W-1:0];
                        if (total >= {1'b0, n_target}) begin
                            status       = ST_COMPLETE;
                            complete     = 1'b1;
                            n_collecting = 1'b0;
                        end else begin
                            status = ST_APPENDED;
                        end
                    end
                end
            end

            n_byte_pos = pos + POS_W'(1);

            n_tdata[7:0]   = stage ? b : 8'd0;
            n_tdata[24:8]  = offset;
            n_tdata[27:25] = status;
            n_tdata[28]    = complete;
            n_tdata[45:29] = n_tlast ? n_committed : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_caption_pid <= PID_RESET;
            r_byte_pos    <= '0;
            r_sync_good   <= 1'b0;
            r_pid_hi      <= '0;
            r_pid_match   <= 1'b0;
            r_unit_start  <= 1'b0;
            r_field_ctl   <= '0;
            r_pay_begin   <= '0;
            r_collecting  <= 1'b0;
            r_committed   <= '0;
            r_target      <= '0;
            r_staged      <= '0;
            r_len_hi      <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_caption_pid <= i_cfg_wr_data;
            end
            if (accept) begin
                r_byte_pos   <= n_byte_pos;
                r_sync_good  <= n_sync_good;
                r_pid_hi     <= n_pid_hi;
                r_pid_match  <= n_pid_match;
                r_unit_start <= n_unit_start;
                r_field_ctl  <= n_field_ctl;
                r_pay_begin  <= n_pay_begin;
                r_collecting <= n_collecting;
                r_committed  <= n_committed;
                r_target     <= n_target;
                r_staged     <= n_staged;
                r_len_hi     <= n_len_hi;
                r_out_valid  <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload: load on accept only
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tdata <= n_tdata;
            r_tuser <= n_tuser;
            r_tlast <= n_tlast;
        end
    end

`ifndef SYNTH
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_pos <= POS_IDLE)
        else $error("byte position past idle");

    a_marker_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready && s_tuser) |=> (r_byte_pos == POS_W'(1)))
        else $error("packet marker did not restart the byte count");

    a_status_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tlast) |-> (m_tdata[28:25] == 4'd0))
        else $error("packet status outside packet end");

    a_complete_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tdata[28]) |-> (m_tdata[27:25] == ST_COMPLETE))
        else $error("completion flag without complete status");
`endif

endmodule

`default_nettype wire

// ===== sim/ts_pid_filter_pes_assembler_tb.sv =====
`timescale 1ns / 100ps

module ts_pid_filter_pes_assembler_tb;
    import tspes_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 60;

    typedef struct {
        logic [7:0] data;
        logic       start;
    } t_ts_in;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [16:0] pes_offset;
        logic        packet_done;
        t_status     status;
        logic        pes_complete;
        logic [16:0] pes_length;
    } t_pes_result;

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_wr_en = 1'b0;
    logic [PID_W-1:0]  i_cfg_wr_data = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata = '0;
    logic              s_tuser = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [47:0]       m_tdata;
    logic              m_tuser;
    logic              m_tlast;

    ts_pid_filter_pes_assembler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast)
    );

    t_ts_in      pending_ts_bytes[$];
    t_pes_result pes_outputs_due[$];
    logic [7:0]  pes_fill[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int          mismatches = 0;
    int          cycle_count = 0;
    logic        hold_arm = 1'b0;
    logic        hold_used;
    int          hold_left = 0;

    logic [PID_W-1:0] sel_pid = PID_RESET;

    // Header parser state of the expected behavior
    logic [7:0]  hp_pos;
    logic        hp_sync_ok;
    logic [4:0]  hp_pid_hi;
    logic        hp_pid_hit;
    logic        hp_unit_start;
    logic [1:0]  hp_afc;
    logic [8:0]  hp_payload_at;
    logic        hp_collecting;
    logic [16:0] hp_committed;
    logic [16:0] hp_target;
    logic [7:0]  hp_staged;
    logic [7:0]  hp_len_hi;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic clear_parser();
        hp_pos        = '0;
        hp_sync_ok    = 1'b0;
        hp_pid_hi     = '0;
        hp_pid_hit    = 1'b0;
        hp_unit_start = 1'b0;
        hp_afc        = '0;
        hp_payload_at = '0;
        hp_collecting = 1'b0;
        hp_committed  = '0;
        hp_target     = '0;
        hp_staged     = '0;
        hp_len_hi     = '0;
    endtask

    task automatic parse_ts_byte(input logic [7:0] b, input logic start,
                                 output t_pes_result r);
        logic [7:0]       pos;
        logic [PID_W-1:0] pid;
        logic [16:0]      base;
        logic [17:0]      total;
        logic             bad_shape;
        r   = '0;
        pos = start ? 8'd0 : hp_pos;
        if (pos >= POS_IDLE) begin
            hp_pos = POS_IDLE;
        end else begin
            case (pos)
                POS_SYNC: begin
                    hp_sync_ok    = (b == SYNC_BYTE);
                    hp_pid_hit    = 1'b0;
                    hp_unit_start = 1'b0;
                    hp_afc        = '0;
                    hp_payload_at = 9'd4;
                    hp_staged     = '0;
                end
                POS_PID_HI: begin
                    hp_pid_hi     = b[4:0];
                    hp_unit_start = b[6];
                end
                POS_PID_LO: begin
                    pid        = {hp_pid_hi, b};
                    hp_pid_hit = hp_sync_ok && (pid == sel_pid);
                end
                POS_CTL: begin
                    hp_afc        = b[5:4];
                    hp_payload_at = 9'd4;
                end
                POS_ADAPT_LEN: begin
                    if (hp_afc[1]) hp_payload_at = 9'd5 + 9'(b);
                end
                default: ;
            endcase

            // payload past the packet, or no room for the PES length bytes
            bad_shape = (hp_payload_at > 9'(PACKET_BYTES)) ||
                        (hp_unit_start && hp_payload_at > 9'(PACKET_BYTES - 6));

            if (pos >= 8'd4 && 9'(pos) >= hp_payload_at && hp_pid_hit &&
                (hp_unit_start || hp_collecting) && !bad_shape) begin
                base            = hp_unit_start ? 17'd0 : hp_committed;
                r.payload_valid = 1'b1;
                r.payload_byte  = b;
                r.pes_offset    = base + 17'(hp_staged);
                if (hp_unit_start) begin
                    if (hp_staged == 8'd4) begin
                        hp_len_hi = b;
                    end else if (hp_staged == 8'd5) begin
                        hp_target = {1'b0, hp_len_hi, b} + 17'd6;
                    end
                end
                hp_staged = hp_staged + 8'd1;
            end

            if (pos == POS_LAST) begin
                r.packet_done = 1'b1;
                if (!hp_sync_ok) begin
                    r.status = ST_BAD_SYNC;
                end else if (!hp_pid_hit) begin
                    r.status = ST_IGNORED;
                end else if (bad_shape) begin
                    r.status = ST_MALFORMED;
                    if (hp_unit_start) begin
                        hp_collecting = 1'b0;
                        hp_committed  = '0;
                        hp_target     = '0;
                    end
                end else if (!hp_unit_start && !hp_collecting) begin
                    r.status = ST_IGNORED;
                end else begin
                    base  = hp_unit_start ? 17'd0 : hp_committed;
                    total = 18'(base) + 18'(hp_staged);
                    if (hp_unit_start) begin
                        hp_collecting = 1'b1;
                        hp_committed  = '0;
                    end
                    if (total > 18'(hp_target)) begin
                        r.status = ST_OVERFLOW;
                    end else begin
                        hp_committed = total[16:0];
                        if (total >= 18'(hp_target)) begin
                            r.status       = ST_COMPLETE;
                            r.pes_complete = 1'b1;
                            hp_collecting  = 1'b0;
                        end else begin
                            r.status = ST_APPENDED;
                        end
                    end
                end
                r.pes_length = hp_committed;
            end
            hp_pos = pos + 8'd1;
        end
    endtask

    // Driver: offer queued bytes, record the expected output of each accepted one
    always @(posedge i_clk) begin : drv
        t_ts_in      nxt;
        t_pes_result r;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            clear_parser();
        end else begin
            if (s_tvalid && s_tready) begin
                parse_ts_byte(s_tdata, s_tuser, r);
                pes_outputs_due.push_back(r);
            end
            if (!s_tvalid || s_tready) begin
                if (pending_ts_bytes.size() != 0 &&
                    $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_ts_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.data;
                    s_tuser  <= nxt.start;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, once, so the input side backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_arm && !hold_used) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
    end

    task automatic compare_field(input string name, input logic [16:0] want,
                                 input logic [16:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : mon
        t_pes_result want;
        t_pes_result got;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.payload_valid = m_tuser;
                got.payload_byte  = m_tdata[7:0];
                got.pes_offset    = m_tdata[24:8];
                got.packet_done   = m_tlast;
                got.status        = t_status'(m_tdata[27:25]);
                got.pes_complete  = m_tdata[28];
                got.pes_length    = m_tdata[45:29];
                if (pes_outputs_due.size() == 0) begin
                    $display("%0t: output item mismatch, expected none, actual %h",
                             $time, got);
                    mismatches++;
                end else begin
                    want = pes_outputs_due.pop_front();
                    compare_field("payload_valid", 17'(want.payload_valid),
                                  17'(got.payload_valid));
                    compare_field("payload_byte", 17'(want.payload_byte),
                                  17'(got.payload_byte));
                    compare_field("pes_offset", want.pes_offset, got.pes_offset);
                    compare_field("packet_done", 17'(want.packet_done),
                                  17'(got.packet_done));
                    compare_field("packet_status", 17'(want.status), 17'(got.status));
                    compare_field("pes_complete", 17'(want.pes_complete),
                                  17'(got.pes_complete));
                    compare_field("pes_length", want.pes_length, got.pes_length);
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic push_byte(input logic [7:0] data, input logic start);
        t_ts_in it;
        it.data  = data;
        it.start = start;
        pending_ts_bytes.push_back(it);
    endtask

    // Queue one packet; payload comes from pes_fill when use_pes is set
    task automatic send_packet(input logic [7:0] sync_b, input logic [PID_W-1:0] pid,
                               input logic pusi, input logic [1:0] afc,
                               input logic [7:0] alen, input int length,
                               input bit mark, input bit use_pes);
        logic [7:0] pkt [PACKET_BYTES];
        int i;
        int pl;
        pkt[0] = sync_b;
        pkt[1] = {1'($urandom_range(1)), pusi, 1'($urandom_range(1)), pid[12:8]};
        pkt[2] = pid[7:0];
        pkt[3] = {2'($urandom_range(3)), afc, 4'($urandom_range(15))};
        pl = 4;
        if (afc[1]) begin
            pkt[4] = alen;
            pl     = 5 + int'(alen);
            for (i = 5; i < pl && i < PACKET_BYTES; i++) pkt[i] = 8'($urandom);
        end
        for (i = pl; i < PACKET_BYTES; i++) begin
            if (use_pes && pes_fill.size() != 0) pkt[i] = pes_fill.pop_front();
            else pkt[i] = 8'($urandom);
        end
        for (i = 0; i < length; i++) push_byte(pkt[i], (i == 0) && mark);
    endtask

    task automatic build_pes(input int len_field, input int max_bytes);
        int i;
        int total;
        total = len_field + 6;
        pes_fill.delete();
        pes_fill.push_back(8'h00);
        pes_fill.push_back(8'h00);
        pes_fill.push_back(8'h01);
        pes_fill.push_back($urandom_range(1) ? 8'hE0 : 8'hBD);
        pes_fill.push_back(8'(len_field >> 8));
        pes_fill.push_back(8'(len_field));
        for (i = 6; i < total && i < max_bytes; i++) pes_fill.push_back(8'($urandom));
    endtask

    // Split one PES packet over transport packets, stuffing the last one unless overflow_tail
    task automatic send_pes(input logic [PID_W-1:0] pid, input int len_field,
                            input int max_packets, input bit overflow_tail,
                            input bit first_mark, input bit with_noise);
        int remaining;
        int pk;
        int cap;
        int alen;
        int sel;
        logic [1:0] afc;
        build_pes(len_field, max_packets * 184);
        remaining = len_field + 6;
        pk = 0;
        while (remaining > 0 && pk < max_packets) begin
            if (with_noise && pk > 0 && $urandom_range(4) == 0)
                send_packet(SYNC_BYTE, pid ^ 13'($urandom_range(8191, 1)),
                            1'($urandom_range(1)), 2'b01, 8'd0, PACKET_BYTES, 1, 0);
            alen = 0;
            cap  = 184;
            if (remaining < 184 && !overflow_tail) begin
                afc  = 2'($urandom_range(3, 2));
                alen = 183 - remaining;
                cap  = remaining;
            end else if (remaining < 184) begin
                afc = 2'b01;
            end else begin
                sel = $urandom_range(7);
                if (sel == 0) begin
                    afc = 2'b00;
                end else if (sel <= 3) begin
                    afc  = (sel == 3) ? 2'b10 : 2'b11;
                    alen = $urandom_range(30);
                    cap  = 183 - alen;
                end else begin
                    afc = 2'b01;
                end
            end
            send_packet(SYNC_BYTE, pid, pk == 0, afc, 8'(alen), PACKET_BYTES,
                        (pk != 0) || first_mark, 1);
            remaining -= (cap < remaining) ? cap : remaining;
            pk++;
        end
        pes_fill.delete();
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (pending_ts_bytes.size() != 0 || s_tvalid || pes_outputs_due.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_pid(input logic [PID_W-1:0] value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sel_pid       <= value;
    endtask

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [PID_W-1:0] pid;
        repeat (8) @(posedge i_clk);
        i_rst_n       <= 1'b1;
        send_idle_pct <= 28;
        recv_idle_pct <= 51;
        @(posedge i_clk);

        // No marker on the very first packet after reset; whole PES in one packet
        send_pes(PID_RESET, 0, 1, 0, 0, 0);
        // Bytes after the packet end with no marker
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(SYNC_BYTE, 1'b0);
        // Bad sync byte
        send_packet(8'hB8, PID_RESET, 1'b1, 2'b01, 8'd0, PACKET_BYTES, 1, 0);
        // Reserved field control on a start packet cut short by the next marker
        build_pes(50, PACKET_BYTES);
        send_packet(SYNC_BYTE, PID_RESET, 1'b1, 2'b00, 8'd0, 60, 1, 1);
        pes_fill.delete();

        wait_drained();
        send_idle_pct <= 51;
        recv_idle_pct <= 28;
        pid = PID_W'($urandom);
        write_pid(pid);
        // Start packet appends, continuation overflows the target
        send_pes(pid, 300, 4, 1, 1, 0);
        // Short start packet abandons the PES in progress
        send_packet(SYNC_BYTE, pid, 1'b1, 2'b11, 8'd180, PACKET_BYTES, 1, 0);

        wait_drained();
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        pid = '0;
        write_pid(pid);
        hold_arm <= 1'b1;
        // One packet holds the whole PES
        send_pes(pid, 177, 1, 0, 1, 0);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pes_outputs_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
